// ===== rtl/cptf_pkg.sv =====
// ----------------------------------------------------------------------------
// cptf_pkg: shared types and constants of the 2D camera point transform
// Item structs, opcodes, register indexes and the divider stage record.
// ----------------------------------------------------------------------------
`default_nettype none

package cptf_pkg;

    // Opcodes of an input item.
    localparam logic OP_W2S = 1'b0;   // world to screen
    localparam logic OP_S2W = 1'b1;   // screen to world

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_ANGLE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_FACTOR = 3'd5;
    localparam int unsigned CFG_DATA_W = 32;

    // Dividend width of the screen-to-world divide (one quotient bit a stage).
    localparam int unsigned DIV_WIDTH = 45;
    localparam int unsigned REM_WIDTH = 16;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } t_in;

    typedef struct packed {
        logic signed [31:0] mapped_x;
        logic signed [31:0] mapped_y;
        logic               overflowed;
    } t_out;

    // One divider stage: quotient/dividend shift words and partial remainders.
    typedef struct packed {
        logic                 opcode;
        logic                 neg_x;
        logic                 neg_y;
        logic [DIV_WIDTH-1:0] q_x;
        logic [REM_WIDTH-1:0] rem_x;
        logic [DIV_WIDTH-1:0] q_y;
        logic [REM_WIDTH-1:0] rem_y;
    } t_div;

endpackage

`default_nettype wire

// ===== rtl/camera_point_transform_2d.sv =====
// ----------------------------------------------------------------------------
// camera_point_transform_2d: 2D camera world/screen point mapping
// Deep pipeline mapping one Q16.16 point per clock through a camera view, unless a full pipeline stalls.
// ----------------------------------------------------------------------------
// One item enters per clock while the input is open; every stage holds its
// item only while the stage ahead is full and stalled, so bubbles close up
// and the input closes only when every stage is full and the output waits.
// The pipeline depth is set by the screen-to-world divide by the
// zoom, which resolves one quotient bit per stage; world-to-screen items ride
// through the same stages. Sine and cosine come from two ROMs of
// SINE_TABLE_DEPTH entries, read once when turn_angle is written, so the
// point path never touches a memory. Configuration is a plain write port
// (write enable, index, 32-bit data) and must be written only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module camera_point_transform_2d #(
    parameter int COORD_WIDTH      = 32,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire cptf_pkg::t_in                      i_item,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output cptf_pkg::t_out                          o_item,
    input  wire logic                               i_cfg_we,
    input  wire logic [cptf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [cptf_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import cptf_pkg::*;

    localparam int AW = $clog2(SINE_TABLE_DEPTH);
    localparam int DW = DIV_WIDTH;
    localparam int MW = 53;          // zoomed product width
    localparam int SW = DW + 2;      // width after adding center or half window
    localparam int UX_W = 36;        // rotated world-to-screen value width

    // Stage map.
    localparam int ST_DIV0 = 6;
    localparam int ST_F1   = ST_DIV0 + DW;
    localparam int NS      = ST_F1 + 3;

    localparam longint MAXV = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
    localparam longint MINV = -MAXV - 64'sd1;
    localparam longint WMAX = MAXV / 65536;
    localparam longint WMIN = -WMAX - 64'sd1;

    typedef logic signed [17:0] t_rom [SINE_TABLE_DEPTH];

    // ------------------------------------------------------------------
    // Sine ROM contents, built at elaboration (Q30 Taylor series to x^11).
    // ------------------------------------------------------------------
    function automatic longint f_quarter_sine(input longint unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        x  = (64'd1686629713 * r) / SINE_TABLE_DEPTH;
        x2 = (x * x) >> 30;
        t  = 64'd1 << 30;
        t  = (64'd1 << 30) - ((x2 * t) >> 30) / 110;
        t  = (64'd1 << 30) - ((x2 * t) >> 30) / 72;
        t  = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
        t  = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
        t  = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
        return longint'((((x * t) >> 30) + 64'd8192) >> 14);
    endfunction

    function automatic longint f_rom_sine(input longint unsigned q4_in);
        longint unsigned q4;
        longint unsigned quad;
        longint unsigned r;
        longint          v;
        q4   = q4_in % (4 * SINE_TABLE_DEPTH);
        quad = q4 / SINE_TABLE_DEPTH;
        r    = q4 % SINE_TABLE_DEPTH;
        case (quad)
            64'd0:   v = f_quarter_sine(r);
            64'd1:   v = f_quarter_sine(SINE_TABLE_DEPTH - r);
            64'd2:   v = -f_quarter_sine(r);
            default: v = -f_quarter_sine(SINE_TABLE_DEPTH - r);
        endcase
        return v;
    endfunction

    function automatic t_rom f_build(input logic cosine);
        t_rom tab;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            tab[k] = 18'(f_rom_sine(longint'(4 * k) +
                                    (cosine ? longint'(SINE_TABLE_DEPTH) : 64'd0)));
        end
        return tab;
    endfunction

    localparam t_rom SIN_ROM = f_build(1'b0);
    localparam t_rom COS_ROM = f_build(1'b1);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic        [13:0]          r_view_w;
    logic        [13:0]          r_view_h;
    logic signed [31:0]          r_center_x;
    logic signed [31:0]          r_center_y;
    logic        [15:0]          r_zoom;
    logic signed [17:0]          r_sin;
    logic signed [17:0]          r_cos;
    logic        [AW-1:0]        angle_idx;
    logic        [REM_WIDTH-1:0] zoom_eff;
    logic signed [32:0]          half_w;
    logic signed [32:0]          half_h;

    // Table index of the written angle: (angle * depth) >> 16.
    assign angle_idx = AW'((32'(i_cfg_wdata[15:0]) * 32'(SINE_TABLE_DEPTH)) >> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_w   <= 14'd1024;
            r_view_h   <= 14'd768;
            r_center_x <= '0;
            r_center_y <= '0;
            r_zoom     <= 16'd256;
            r_sin      <= SIN_ROM[0];
            r_cos      <= COS_ROM[0];
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VIEW_WIDTH:  r_view_w   <= i_cfg_wdata[13:0];
                CFG_VIEW_HEIGHT: r_view_h   <= i_cfg_wdata[13:0];
                CFG_CENTER_X:    r_center_x <= i_cfg_wdata;
                CFG_CENTER_Y:    r_center_y <= i_cfg_wdata;
                CFG_TURN_ANGLE: begin
                    // read both ROMs at the new angle
                    r_sin <= SIN_ROM[angle_idx];
                    r_cos <= COS_ROM[angle_idx];
                end
                CFG_ZOOM_FACTOR: r_zoom     <= i_cfg_wdata[15:0];
                default: ;   // drop writes beyond the register list
            endcase
        end
    end

    // Zoom of zero acts as 1/256.
    assign zoom_eff = (r_zoom == '0) ? 16'd1 : r_zoom;
    assign half_w   = 33'($signed({1'b0, r_view_w, 15'd0}));
    assign half_h   = 33'($signed({1'b0, r_view_h, 15'd0}));

    // ------------------------------------------------------------------
    // Valid bits and per-stage advance: a stage loads when it is empty or
    // the stage ahead loads, so bubbles collapse.
    // ------------------------------------------------------------------
    logic [NS-1:0] r_vld;
    logic [NS:0]   adv;

    always_comb begin
        adv[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= (k == 0) ? i_valid : r_vld[k-1];
                end
            end
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_vld[NS-1];

    // ------------------------------------------------------------------
    // Stage 1: offsets from the center (world) or from the window (screen).
    // ------------------------------------------------------------------
    logic               r1_op;
    logic signed [32:0] r1_a;
    logic signed [32:0] r1_b;

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r1_op <= i_item.opcode;
            if (i_item.opcode == OP_W2S) begin
                r1_a <= 33'(i_item.point_x) - 33'(r_center_x);
                r1_b <= 33'(i_item.point_y) - 33'(r_center_y);
            end else begin
                r1_a <= 33'(i_item.point_x) - half_w;
                r1_b <= half_h - 33'(i_item.point_y);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the four rotation products.
    // ------------------------------------------------------------------
    logic               r2_op;
    logic signed [50:0] r2_p1;
    logic signed [50:0] r2_p2;
    logic signed [50:0] r2_p3;
    logic signed [50:0] r2_p4;
    logic signed [50:0] sin_w;
    logic signed [50:0] cos_w;
    logic signed [50:0] a_w;
    logic signed [50:0] b_w;

    assign sin_w = 51'(r_sin);
    assign cos_w = 51'(r_cos);
    assign a_w   = 51'(r1_a);
    assign b_w   = 51'(r1_b);

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r2_op <= r1_op;
            r2_p1 <= cos_w * a_w;
            r2_p2 <= sin_w * b_w;
            r2_p3 <= sin_w * a_w;
            r2_p4 <= cos_w * b_w;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: rotate forward (world) or back (screen).
    // ------------------------------------------------------------------
    logic               r3_op;
    logic signed [51:0] r3_x;
    logic signed [51:0] r3_y;

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r3_op <= r2_op;
            if (r2_op == OP_W2S) begin
                r3_x <= 52'(r2_p1) - 52'(r2_p2);
                r3_y <= 52'(r2_p3) + 52'(r2_p4);
            end else begin
                r3_x <= 52'(r2_p1) + 52'(r2_p2);
                r3_y <= 52'(r2_p4) - 52'(r2_p3);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: round to Q16 (world), or fold the 256/(zoom*65536) rounding
    // bias into the dividend: floor((x + 128 z) / 256) (screen).
    // ------------------------------------------------------------------
    logic               r4_op;
    logic signed [DW-1:0] r4_x;
    logic signed [DW-1:0] r4_y;
    logic signed [51:0] bias_z;
    logic signed [51:0] s4_x;
    logic signed [51:0] s4_y;

    assign bias_z = 52'($signed({1'b0, zoom_eff, 7'd0}));

    always_comb begin
        if (r3_op == OP_W2S) begin
            s4_x = (r3_x + 52'sd32768) >>> 16;
            s4_y = (r3_y + 52'sd32768) >>> 16;
        end else begin
            s4_x = (r3_x + bias_z) >>> 8;
            s4_y = (r3_y + bias_z) >>> 8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r4_op <= r3_op;
            r4_x  <= DW'(s4_x);
            r4_y  <= DW'(s4_y);
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: scale by the zoom (world); hold the dividend (screen).
    // ------------------------------------------------------------------
    logic                 r5_op;
    logic signed [MW-1:0] r5_x;
    logic signed [MW-1:0] r5_y;
    logic signed [MW-1:0] zoom_w;
    logic signed [MW-1:0] ux_w;
    logic signed [MW-1:0] uy_w;

    assign zoom_w = MW'($signed({1'b0, zoom_eff}));
    assign ux_w   = MW'($signed(r4_x[UX_W-1:0]));
    assign uy_w   = MW'($signed(r4_y[UX_W-1:0]));

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r5_op <= r4_op;
            if (r4_op == OP_W2S) begin
                r5_x <= ux_w * zoom_w;
                r5_y <= uy_w * zoom_w;
            end else begin
                r5_x <= MW'(r4_x);
                r5_y <= MW'(r4_y);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: round the zoomed value (world); split sign and magnitude for
    // the divider (screen).
    // ------------------------------------------------------------------
    t_div                 r6_div;
    t_div                 n6_div;
    logic signed [MW-1:0] s6_x;
    logic signed [MW-1:0] s6_y;

    always_comb begin
        s6_x   = (r5_x + MW'(128)) >>> 8;
        s6_y   = (r5_y + MW'(128)) >>> 8;
        n6_div = '0;
        n6_div.opcode = r5_op;
        if (r5_op == OP_W2S) begin
            n6_div.q_x = DW'(s6_x);
            n6_div.q_y = DW'(s6_y);
        end else begin
            n6_div.neg_x = r5_x[MW-1];
            n6_div.neg_y = r5_y[MW-1];
            n6_div.q_x   = r5_x[MW-1] ? DW'(-r5_x) : DW'(r5_x);
            n6_div.q_y   = r5_y[MW-1] ? DW'(-r5_y) : DW'(r5_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r6_div <= n6_div;
        end
    end

    // ------------------------------------------------------------------
    // Divider: one quotient bit per stage.
    // ------------------------------------------------------------------
    t_div div_q [DW+1];

    assign div_q[0] = r6_div;

    for (genvar g = 0; g < DW; g++) begin : g_div
        cptf_div_step u_step (
            .i_clk   (i_clk),
            .i_en    (adv[ST_DIV0 + g]),
            .i_zoom  (zoom_eff),
            .i_stage (div_q[g]),
            .o_stage (div_q[g+1])
        );
    end

    // ------------------------------------------------------------------
    // F1: floor the signed quotient (screen); pass (world).
    // ------------------------------------------------------------------
    t_div                 div_o;
    logic                 r7_op;
    logic signed [DW-1:0] r7_x;
    logic signed [DW-1:0] r7_y;

    assign div_o = div_q[DW];

    always_ff @(posedge i_clk) begin
        if (adv[ST_F1]) begin
            r7_op <= div_o.opcode;
            if (div_o.opcode == OP_W2S) begin
                r7_x <= div_o.q_x;
                r7_y <= div_o.q_y;
            end else begin
                r7_x <= div_o.neg_x ? -(div_o.q_x + DW'(div_o.rem_x != '0)) : div_o.q_x;
                r7_y <= div_o.neg_y ? -(div_o.q_y + DW'(div_o.rem_y != '0)) : div_o.q_y;
            end
        end
    end

    // ------------------------------------------------------------------
    // F2: add the half window and flip y (world); add the center (screen).
    // ------------------------------------------------------------------
    logic                 r8_op;
    logic signed [SW-1:0] r8_x;
    logic signed [SW-1:0] r8_y;

    always_ff @(posedge i_clk) begin
        if (adv[ST_F1 + 1]) begin
            r8_op <= r7_op;
            if (r7_op == OP_W2S) begin
                r8_x <= SW'(r7_x) + SW'(half_w);
                r8_y <= SW'(half_h) - SW'(r7_y);
            end else begin
                r8_x <= SW'(r_center_x) + SW'(r7_x);
                r8_y <= SW'(r_center_y) + SW'(r7_y);
            end
        end
    end

    // ------------------------------------------------------------------
    // F3: truncate to whole units (screen) and saturate; output register.
    // ------------------------------------------------------------------
    t_out   r_out;
    t_out   n_out;
    longint vx;
    longint vy;
    longint lo;
    longint hi;
    longint cx;
    longint cy;
    logic   sat_x;
    logic   sat_y;

    always_comb begin
        vx = longint'(r8_x);
        vy = longint'(r8_y);
        if (r8_op == OP_W2S) begin
            lo = MINV;
            hi = MAXV;
        end else begin
            // truncate toward zero to whole units
            vx = (vx < 0) ? ((vx + 64'sd65535) >>> 16) : (vx >>> 16);
            vy = (vy < 0) ? ((vy + 64'sd65535) >>> 16) : (vy >>> 16);
            lo = WMIN;
            hi = WMAX;
        end
        sat_x = (vx > hi) || (vx < lo);
        sat_y = (vy > hi) || (vy < lo);
        cx = (vx > hi) ? hi : ((vx < lo) ? lo : vx);
        cy = (vy > hi) ? hi : ((vy < lo) ? lo : vy);
        if (r8_op == OP_S2W) begin
            cx = cx <<< 16;
            cy = cy <<< 16;
        end
        n_out.mapped_x   = 32'(cx);
        n_out.mapped_y   = 32'(cy);
        n_out.overflowed = sat_x || sat_y;
    end

    always_ff @(posedge i_clk) begin
        if (adv[NS-1]) begin
            r_out <= n_out;
        end
    end

    assign o_item = r_out;

endmodule

`default_nettype wire

// ===== rtl/cptf_div_step.sv =====
// ----------------------------------------------------------------------------
// cptf_div_step: one restoring divide step for both coordinates
// Shifts one dividend bit into each remainder and produces one quotient bit.
// World-to-screen items pass unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module cptf_div_step (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire logic [cptf_pkg::REM_WIDTH-1:0]      i_zoom,
    input  wire cptf_pkg::t_div                      i_stage,
    output cptf_pkg::t_div                           o_stage
);
    import cptf_pkg::*;

    t_div r_stage;
    t_div n_stage;

    logic [REM_WIDTH:0] trial_x;
    logic [REM_WIDTH:0] trial_y;
    logic               ge_x;
    logic               ge_y;

    always_comb begin
        trial_x = {i_stage.rem_x, i_stage.q_x[DIV_WIDTH-1]};
        trial_y = {i_stage.rem_y, i_stage.q_y[DIV_WIDTH-1]};
        ge_x    = trial_x >= {1'b0, i_zoom};
        ge_y    = trial_y >= {1'b0, i_zoom};
        n_stage = i_stage;
        if (i_stage.opcode == OP_S2W) begin
            n_stage.q_x   = {i_stage.q_x[DIV_WIDTH-2:0], ge_x};
            n_stage.q_y   = {i_stage.q_y[DIV_WIDTH-2:0], ge_y};
            n_stage.rem_x = ge_x ? REM_WIDTH'(trial_x - {1'b0, i_zoom})
                                 : trial_x[REM_WIDTH-1:0];
            n_stage.rem_y = ge_y ? REM_WIDTH'(trial_y - {1'b0, i_zoom})
                                 : trial_y[REM_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

`default_nettype wire

// ===== rtl/cptf_checker.sv =====
// ----------------------------------------------------------------------------
// cptf_checker: port-level assertions for the camera point transform
// Watches the handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

module cptf_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_valid,
    input wire logic                            o_ready,
    input wire cptf_pkg::t_in                   i_item,
    input wire logic                            o_valid,
    input wire logic                            i_ready,
    input wire cptf_pkg::t_out                  o_item
);
    import cptf_pkg::*;

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("item shown right after reset");

    // A stalled item holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("stalled output item changed or vanished");

    // An offered input item holds until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_item))
        else $error("offered input item changed or vanished");

    // An empty output slot leaves the input open.
    a_open_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input closed with empty output");

    // A draining output never blocks the input.
    a_open_when_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("input closed while output drains");

endmodule

bind camera_point_transform_2d cptf_checker u_cptf_checker (.*);

`default_nettype wire
